>>> rtl/core/nta_pkg.sv
package nta_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IFACE_COUNT = 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int IFACE_W     = 2;
  localparam int CNT_W       = 5;
  localparam int AGE_W       = 10;
  localparam int WORD_W      = 32;
  localparam int INTERVAL_W  = 8;
  localparam int AGE_FACTOR  = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [AGE_W-1:0]      AGE_MAX        = 10'd1023;
  localparam logic [CNT_W-1:0]      CNT_MAX        = 5'd31;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd5;

  typedef enum logic [1:0] {
    CMD_HELLO,
    CMD_BAD_IFACE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [IFACE_W-1:0]  iface;
    logic [WORD_W-1:0]   rid;
    logic [WORD_W-1:0]   ip;
    logic [WORD_W-1:0]   mask;
  } cmd_t;

  typedef enum logic [2:0] {
    STATUS_REFRESHED = 3'd0,
    STATUS_INSERTED  = 3'd1,
    STATUS_DROPPED   = 3'd2,
    STATUS_EVICTED   = 3'd3,
    STATUS_TICK_DONE = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [IFACE_W-1:0]  iface;
    logic [WORD_W-1:0]   rid;
    logic [WORD_W-1:0]   ip;
    logic [CNT_W-1:0]    count;
    logic                last;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HELLO,
    S_TICK,
    S_FINISH
  } state_t;

endpackage

>>> rtl/core/nta_if.sv
interface nta_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [1:0]  iface_index;
  logic [31:0] nbr_rid;
  logic [31:0] nbr_ip;
  logic [31:0] hello_mask;

  modport source (output valid, req_type, iface_index, nbr_rid, nbr_ip, hello_mask,
                  input ready);
  modport sink (input valid, req_type, iface_index, nbr_rid, nbr_ip, hello_mask,
                output ready);
endinterface

interface nta_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  out_iface;
  logic [31:0] out_rid;
  logic [31:0] out_ip;
  logic [4:0]  iface_nbr_count;
  logic        last;

  modport source (output valid, status, out_iface, out_rid, out_ip, iface_nbr_count, last,
                  input ready);
  modport sink (input valid, status, out_iface, out_rid, out_ip, iface_nbr_count, last,
                output ready);
endinterface

interface nta_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] hello_interval;

  modport source (output valid, hello_interval, input ready);
  modport sink (input valid, hello_interval, output ready);
endinterface

>>> rtl/core/nta_front.sv
module nta_front (
  nta_req_if.sink        req,
  output logic           push_valid,
  output nta_pkg::cmd_t  push_cmd,
  input  logic           push_ready
);

  logic bad_iface;

  assign bad_iface = ({1'b0, req.iface_index} >= 3'(nta_pkg::IFACE_COUNT));

  always_comb begin
    push_cmd.iface = req.iface_index;
    push_cmd.rid   = req.nbr_rid;
    push_cmd.ip    = req.nbr_ip;
    push_cmd.mask  = req.hello_mask;
    if (req.req_type) begin
      push_cmd.kind = nta_pkg::CMD_TICK;
    end else if (bad_iface) begin
      push_cmd.kind = nta_pkg::CMD_BAD_IFACE;
    end else begin
      push_cmd.kind = nta_pkg::CMD_HELLO;
    end
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

endmodule

>>> rtl/core/nta_queue.sv
module nta_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  nta_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output nta_pkg::cmd_t  pop_cmd,
  input  logic           pop_ready
);

  nta_pkg::cmd_t                slots [nta_pkg::QUEUE_DEPTH];
  logic [nta_pkg::QPTR_W-1:0]   wr_ptr;
  logic [nta_pkg::QPTR_W-1:0]   rd_ptr;
  logic [nta_pkg::QCNT_W-1:0]   fill;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (fill != nta_pkg::QCNT_W'(nta_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == nta_pkg::QPTR_W'(nta_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == nta_pkg::QPTR_W'(nta_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/nta_back.sv
module nta_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  nta_pkg::cmd_t  cmd,
  output logic           cmd_ready,
  nta_cfg_if.sink        cfg,
  nta_res_if.source      res
);

  nta_pkg::state_t                  state;
  nta_pkg::state_t                  state_next;
  logic [nta_pkg::IDX_W-1:0]        idx;
  logic [nta_pkg::IDX_W-1:0]        free_idx;
  logic                             free_found;
  nta_pkg::cmd_t                    cur;
  logic [nta_pkg::INTERVAL_W-1:0]   hello_interval;

  logic [nta_pkg::TABLE_DEPTH-1:0]  entry_valid;
  logic [nta_pkg::IFACE_W-1:0]      entry_iface [nta_pkg::TABLE_DEPTH];
  logic [nta_pkg::WORD_W-1:0]       entry_rid   [nta_pkg::TABLE_DEPTH];
  logic [nta_pkg::WORD_W-1:0]       entry_ip    [nta_pkg::TABLE_DEPTH];
  logic [nta_pkg::WORD_W-1:0]       entry_mask  [nta_pkg::TABLE_DEPTH];
  logic [nta_pkg::AGE_W-1:0]        entry_age   [nta_pkg::TABLE_DEPTH];
  logic [nta_pkg::CNT_W-1:0]        iface_count [nta_pkg::IFACE_COUNT];

  logic                             out_valid;
  nta_pkg::res_t                    out_res;
  nta_pkg::res_t                    res_next;

  logic [nta_pkg::AGE_W-1:0]        limit;
  logic                             out_free;
  logic                             at_last;
  logic                             e_valid;
  logic [nta_pkg::IFACE_W-1:0]      e_iface;
  logic [nta_pkg::WORD_W-1:0]       e_rid;
  logic [nta_pkg::WORD_W-1:0]       e_ip;
  logic [nta_pkg::AGE_W-1:0]        e_age;
  logic                             hit;
  logic                             expire;
  logic [nta_pkg::CNT_W-1:0]        cur_cnt;
  logic [nta_pkg::CNT_W-1:0]        inc_cnt;
  logic [nta_pkg::CNT_W-1:0]        ev_cnt;
  logic [nta_pkg::CNT_W-1:0]        dec_cnt;

  logic                             emit;
  logic                             advance;
  logic                             note_free;
  logic                             age_clear;
  logic                             age_inc;
  logic                             evict;
  logic                             insert;
  logic                             cmd_take;

  assign limit    = nta_pkg::AGE_W'(hello_interval) * nta_pkg::AGE_W'(nta_pkg::AGE_FACTOR);
  assign out_free = !out_valid || res.ready;
  assign at_last  = (idx == nta_pkg::IDX_W'(nta_pkg::TABLE_DEPTH - 1));
  assign e_valid  = entry_valid[idx];
  assign e_iface  = entry_iface[idx];
  assign e_rid    = entry_rid[idx];
  assign e_ip     = entry_ip[idx];
  assign e_age    = entry_age[idx];
  assign hit      = e_valid && (e_iface == cur.iface) && (e_rid == cur.rid);
  assign expire   = e_valid && (e_age >= limit);
  assign cur_cnt  = iface_count[cur.iface];
  assign inc_cnt  = (cur_cnt < nta_pkg::CNT_MAX) ? cur_cnt + 1'b1 : cur_cnt;
  assign ev_cnt   = iface_count[e_iface];
  assign dec_cnt  = (ev_cnt != '0) ? ev_cnt - 1'b1 : ev_cnt;
  assign cmd_take = cmd_valid && cmd_ready;

  always_comb begin
    state_next = state;
    case (state)
      nta_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            nta_pkg::CMD_HELLO: state_next = nta_pkg::S_HELLO;
            nta_pkg::CMD_TICK:  state_next = nta_pkg::S_TICK;
            default:            state_next = nta_pkg::S_FINISH;
          endcase
        end
      end
      nta_pkg::S_HELLO: begin
        if (hit) begin
          if (out_free) begin
            state_next = nta_pkg::S_IDLE;
          end
        end else if (at_last) begin
          state_next = nta_pkg::S_FINISH;
        end
      end
      nta_pkg::S_TICK: begin
        if (!(expire && !out_free) && at_last) begin
          state_next = nta_pkg::S_FINISH;
        end
      end
      nta_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = nta_pkg::S_IDLE;
        end
      end
      default: state_next = nta_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    emit      = 1'b0;
    advance   = 1'b0;
    note_free = 1'b0;
    age_clear = 1'b0;
    age_inc   = 1'b0;
    evict     = 1'b0;
    insert    = 1'b0;
    res_next  = '0;
    case (state)
      nta_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
      end
      nta_pkg::S_HELLO: begin
        if (hit) begin
          if (out_free) begin
            emit      = 1'b1;
            age_clear = 1'b1;
            res_next  = '{nta_pkg::STATUS_REFRESHED, cur.iface, cur.rid, e_ip, cur_cnt, 1'b1};
          end
        end else begin
          advance   = 1'b1;
          note_free = !e_valid && !free_found;
        end
      end
      nta_pkg::S_TICK: begin
        if (expire) begin
          if (out_free) begin
            emit     = 1'b1;
            evict    = 1'b1;
            advance  = 1'b1;
            res_next = '{nta_pkg::STATUS_EVICTED, e_iface, e_rid, e_ip, dec_cnt, 1'b0};
          end
        end else begin
          advance = 1'b1;
          age_inc = e_valid && (e_age < nta_pkg::AGE_MAX);
        end
      end
      nta_pkg::S_FINISH: begin
        if (out_free) begin
          emit = 1'b1;
          case (cur.kind)
            nta_pkg::CMD_TICK: begin
              res_next = '{nta_pkg::STATUS_TICK_DONE, '0, '0, '0, '0, 1'b1};
            end
            nta_pkg::CMD_BAD_IFACE: begin
              res_next = '{nta_pkg::STATUS_DROPPED, cur.iface, cur.rid, cur.ip, '0, 1'b1};
            end
            default: begin
              if (free_found) begin
                insert   = 1'b1;
                res_next = '{nta_pkg::STATUS_INSERTED, cur.iface, cur.rid, cur.ip, inc_cnt,
                             1'b1};
              end else begin
                res_next = '{nta_pkg::STATUS_DROPPED, cur.iface, cur.rid, cur.ip, cur_cnt,
                             1'b1};
              end
            end
          endcase
        end
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= nta_pkg::S_IDLE;
      idx            <= '0;
      free_found     <= 1'b0;
      hello_interval <= nta_pkg::INTERVAL_RESET;
      entry_valid    <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < nta_pkg::IFACE_COUNT; i++) begin
        iface_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        hello_interval <= cfg.hello_interval;
      end
      if (cmd_take) begin
        idx        <= '0;
        free_found <= 1'b0;
      end else if (advance) begin
        idx <= idx + 1'b1;
      end
      if (note_free) begin
        free_found <= 1'b1;
      end
      if (evict) begin
        entry_valid[idx]     <= 1'b0;
        iface_count[e_iface] <= dec_cnt;
      end
      if (insert) begin
        entry_valid[free_idx]  <= 1'b1;
        iface_count[cur.iface] <= inc_cnt;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
    if (note_free) begin
      free_idx <= idx;
    end
    if (emit) begin
      out_res <= res_next;
    end
    if (age_clear) begin
      entry_age[idx] <= '0;
    end else if (age_inc) begin
      entry_age[idx] <= e_age + 1'b1;
    end
    if (insert) begin
      entry_iface[free_idx] <= cur.iface;
      entry_rid[free_idx]   <= cur.rid;
      entry_ip[free_idx]    <= cur.ip;
      entry_mask[free_idx]  <= cur.mask;
      entry_age[free_idx]   <= '0;
    end
  end

  assign cfg.ready           = 1'b1;
  assign res.valid           = out_valid;
  assign res.status          = out_res.status;
  assign res.out_iface       = out_res.iface;
  assign res.out_rid         = out_res.rid;
  assign res.out_ip          = out_res.ip;
  assign res.iface_nbr_count = out_res.count;
  assign res.last            = out_res.last;

endmodule

>>> rtl/core/neighbor_table_with_aging.sv
// Neighbor table with aging. Items arrive on the req channel: a hello looks up
// its router id on its interface and refreshes, inserts or drops the neighbor,
// and a tick ages every entry and removes those that have expired.
// Results leave on the res channel, one per hello, and for a tick one per
// evicted entry followed by a tick-done result that carries last.
// The cfg channel writes the hello interval; it is always ready and must only
// be used while the block is idle.
// Accepted items pass through a two-entry queue to a table engine that
// visits one table slot per cycle while its output is not stalled. A hello
// scans the slots until it finds its neighbor or reaches the last slot, and a
// tick scans every slot; each result is written to the output register.
// The engine takes a new item only once it is done with the last one.
// Results sit in an output register; when the receiver stalls, the engine
// holds at the slot that wants to report, and the queue keeps taking items
// until it is full.
// Synchronous reset empties the table, clears every interface count, sets
// the hello interval to 5 and drops any queued item or pending result.
module neighbor_table_with_aging (
  input  logic      clk,
  input  logic      rst,
  nta_req_if.sink   req,
  nta_res_if.source res,
  nta_cfg_if.sink   cfg
);

  logic           push_valid;
  logic           push_ready;
  nta_pkg::cmd_t  push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  nta_pkg::cmd_t  pop_cmd;

  nta_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  nta_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  nta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop_ready),
    .cfg       (cfg),
    .res       (res)
  );

endmodule
